// ----- hw/rtl/efd_pkg.sv -----
// Shared types and constants for the escaped frame deframer.
// Holds result kind codes and register indexes; no dependencies.
`default_nettype none

package efd_pkg;

   typedef enum logic [2:0] {
      KIND_DATA          = 3'd0,
      KIND_ACCEPTED      = 3'd1,
      KIND_MISMATCH      = 3'd2,
      KIND_NOT_CONNECTED = 3'd3,
      KIND_ESCAPE_ERROR  = 3'd4,
      KIND_STRAY_START   = 3'd5,
      KIND_OVERFLOW      = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      REG_START_CODE    = 3'd0,
      REG_END_CODE      = 3'd1,
      REG_ESCAPE_CODE   = 3'd2,
      REG_LOCAL_ADDRESS = 3'd3,
      REG_LINK_ACTIVE   = 3'd4
   } reg_index_type;

   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [7:0]  START_CODE_RESET  = 8'd2;
   localparam logic [7:0]  END_CODE_RESET    = 8'd3;
   localparam logic [7:0]  ESCAPE_CODE_RESET = 8'd16;
   localparam logic [31:0] ADDRESS_RESET     = 32'd0;

endpackage

`default_nettype wire

// ----- hw/rtl/escaped_frame_deframer_unit.sv -----
// Escaped frame deframer top level: stuffed byte stream in, data and status words out.
// Depends on efd_pkg for kind codes and register indexes.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_rx_byte
//   rsp      out        rsp_valid/stall    rsp_item_kind, rsp_data_byte,
//                                          rsp_byte_index, rsp_frame_length
//   csr      in/out     APB-style          csr_paddr, csr_pwdata, csr_prdata
//
// One byte accepted per cycle while req_stall is low; any result word it yields
// appears in the single result register the following cycle.
// Synchronous reset clears frame state and output valid and resets the CSRs.
// req_stall rises only while a result word is held and rsp_stall is high.
`default_nettype none

module escaped_frame_deframer_unit #(
   parameter int unsigned MAX_FRAME_BYTES = 2048
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_rx_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [2:0]                          rsp_item_kind,
   output logic [7:0]                          rsp_data_byte,
   output logic [10:0]                         rsp_byte_index,
   output logic [11:0]                         rsp_frame_length,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [efd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

   logic [7:0]  start_code_ff;
   logic [7:0]  end_code_ff;
   logic [7:0]  escape_code_ff;
   logic [31:0] local_address_ff;
   logic        link_active_ff;

   logic             inside_ff,   inside_in;
   logic             escape_ff,   escape_in;
   logic [CNT_W-1:0] count_ff,    count_in;
   logic [15:0]      declared_ff, declared_in;
   logic             overflow_ff, overflow_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   efd_pkg::kind_type    kind_ff,      kind_in;
   logic [7:0]           data_ff,      data_in;
   logic [10:0]          index_ff,     index_in;
   logic [11:0]          length_ff,    length_in;

   logic                   csr_write;
   efd_pkg::reg_index_type csr_index;
   logic                   req_accept;
   logic                   out_free;
   logic [15:0]            count_wide;
   logic [7:0]             c;
   logic                   take;
   logic                   close;
   efd_pkg::kind_type      close_kind;

   assign csr_pready = 1'b1;
   assign csr_index  = efd_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         efd_pkg::REG_START_CODE:    csr_prdata = {24'd0, start_code_ff};
         efd_pkg::REG_END_CODE:      csr_prdata = {24'd0, end_code_ff};
         efd_pkg::REG_ESCAPE_CODE:   csr_prdata = {24'd0, escape_code_ff};
         efd_pkg::REG_LOCAL_ADDRESS: csr_prdata = local_address_ff;
         efd_pkg::REG_LINK_ACTIVE:   csr_prdata = {31'd0, link_active_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   assign out_free   = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !out_free;
   assign req_accept = req_valid && out_free;
   assign count_wide = 16'(count_ff);
   assign c          = req_rx_byte;

   always_comb begin
      inside_in   = inside_ff;
      escape_in   = escape_ff;
      count_in    = count_ff;
      declared_in = declared_ff;
      overflow_in = overflow_ff;
      take        = 1'b0;
      close       = 1'b0;
      close_kind  = efd_pkg::KIND_ACCEPTED;

      if (!inside_ff) begin
         if (c == start_code_ff) begin
            inside_in   = 1'b1;
            escape_in   = 1'b0;
            count_in    = '0;
            declared_in = 16'd0;
            overflow_in = 1'b0;
         end
      end else if (escape_ff) begin
         escape_in = 1'b0;
         if (c == start_code_ff || c == end_code_ff || c == escape_code_ff) begin
            take = 1'b1;
         end else begin
            close      = 1'b1;
            close_kind = efd_pkg::KIND_ESCAPE_ERROR;
         end
      end else if (c == start_code_ff) begin
         close      = 1'b1;
         close_kind = efd_pkg::KIND_STRAY_START;
      end else if (c == end_code_ff) begin
         close = 1'b1;
         if (overflow_ff) begin
            close_kind = efd_pkg::KIND_OVERFLOW;
         end else if (local_address_ff == 32'd0 || !link_active_ff) begin
            close_kind = efd_pkg::KIND_NOT_CONNECTED;
         end else if (declared_ff != count_wide) begin
            close_kind = efd_pkg::KIND_MISMATCH;
         end else begin
            close_kind = efd_pkg::KIND_ACCEPTED;
         end
      end else if (c == escape_code_ff) begin
         escape_in = 1'b1;
      end else begin
         take = 1'b1;
      end

      if (close) begin
         inside_in = 1'b0;
         escape_in = 1'b0;
      end

      kind_in      = efd_pkg::KIND_DATA;
      data_in      = 8'd0;
      index_in     = 11'd0;
      length_in    = 12'd0;
      rsp_valid_in = 1'b0;

      if (take) begin
         if (count_wide >= 16'(MAX_FRAME_BYTES)) begin
            overflow_in = 1'b1;
         end else begin
            if (count_wide == 16'd2) begin
               declared_in = {c, declared_ff[7:0]};
            end else if (count_wide == 16'd3) begin
               declared_in = {declared_ff[15:8], c};
            end
            count_in     = count_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            kind_in      = efd_pkg::KIND_DATA;
            data_in      = c;
            index_in     = count_wide[10:0];
         end
      end else if (close) begin
         rsp_valid_in = 1'b1;
         kind_in      = close_kind;
         length_in    = count_wide[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff    <= efd_pkg::START_CODE_RESET;
         end_code_ff      <= efd_pkg::END_CODE_RESET;
         escape_code_ff   <= efd_pkg::ESCAPE_CODE_RESET;
         local_address_ff <= efd_pkg::ADDRESS_RESET;
         link_active_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            efd_pkg::REG_START_CODE:    start_code_ff    <= csr_pwdata[7:0];
            efd_pkg::REG_END_CODE:      end_code_ff      <= csr_pwdata[7:0];
            efd_pkg::REG_ESCAPE_CODE:   escape_code_ff   <= csr_pwdata[7:0];
            efd_pkg::REG_LOCAL_ADDRESS: local_address_ff <= csr_pwdata;
            efd_pkg::REG_LINK_ACTIVE:   link_active_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         escape_ff    <= 1'b0;
         count_ff     <= '0;
         declared_ff  <= 16'd0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            inside_ff   <= inside_in;
            escape_ff   <= escape_in;
            count_ff    <= count_in;
            declared_ff <= declared_in;
            overflow_ff <= overflow_in;
         end
         if (out_free) begin
            rsp_valid_ff <= req_accept && rsp_valid_in;
         end
      end
   end

   // load payload only with a fresh word; hold while stalled
   always_ff @(posedge clock) begin
      if (out_free && req_accept && rsp_valid_in) begin
         kind_ff   <= kind_in;
         data_ff   <= data_in;
         index_ff  <= index_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_item_kind    = kind_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_byte_index   = index_ff;
   assign rsp_frame_length = length_ff;

endmodule

`default_nettype wire
